// ===== sv/dcd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double clap detector: widths, register map, reset values
// and the structs shared between the submodules. No dependencies.
package dcd_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int THR_BITS          = 12;
  localparam int WIN_BITS          = 16;
  localparam int TIME_BITS         = 32;
  localparam int ADDR_BITS         = 3;
  localparam int DATA_BITS         = 32;

  localparam logic [THR_BITS-1:0] THR_RESET = 12'd100;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd500;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_WINDOW    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [THR_BITS-1:0] threshold;
    logic [WIN_BITS-1:0] window_ms;
  } cfg_t;

  // level tracker status for the window logic
  typedef struct packed {
    logic seed;  // item only seeded the average
    logic clap;  // item was above average plus threshold
  } lvl_t;

endpackage

// ===== sv/dcd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the double clap detector: valid/ready plus sample item.
// Depends on dcd_pkg.
interface dcd_in_if #(
  parameter int SAMPLE_BITS = dcd_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [SAMPLE_BITS-1:0]         sample;
  logic [dcd_pkg::TIME_BITS-1:0]  time_ms;

  modport source (output valid, sample, time_ms, input ready);
  modport sink   (input valid, sample, time_ms, output ready);
endinterface

// ===== sv/dcd_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the double clap detector: valid/ready plus result item.
// Depends on dcd_pkg.
interface dcd_out_if #(
  parameter int SAMPLE_BITS = dcd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   toggle;
  logic                   clap_seen;
  logic [SAMPLE_BITS-1:0] level_average;

  modport source (output valid, toggle, clap_seen, level_average, input ready);
  modport sink   (input valid, toggle, clap_seen, level_average, output ready);
endinterface

// ===== sv/dcd_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB configuration registers: clap threshold and clap window.
// Depends on dcd_pkg.
module dcd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [dcd_pkg::DATA_BITS-1:0] pwdata,
  output logic [dcd_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output dcd_pkg::cfg_t                 cfg_o
);

  dcd_pkg::cfg_t     cfg_q, cfg_d;
  dcd_pkg::reg_idx_e idx;
  logic              wr_en;

  // registers sit at 4-byte spacing; low address bits are ignored
  assign idx    = dcd_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        dcd_pkg::REG_THRESHOLD: cfg_d.threshold = pwdata[dcd_pkg::THR_BITS-1:0];
        dcd_pkg::REG_WINDOW:    cfg_d.window_ms = pwdata[dcd_pkg::WIN_BITS-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dcd_pkg::REG_THRESHOLD:
        prdata = dcd_pkg::DATA_BITS'(cfg_q.threshold);
      dcd_pkg::REG_WINDOW:
        prdata = dcd_pkg::DATA_BITS'(cfg_q.window_ms);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= dcd_pkg::THR_RESET;
      cfg_q.window_ms <= dcd_pkg::WIN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/dcd_level_tracker.sv =====
`timescale 1ns / 1ps
// Running average of the sound level in fixed point and clap detection.
// Depends on dcd_pkg.
module dcd_level_tracker #(
  parameter int SAMPLE_BITS   = dcd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = dcd_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [dcd_pkg::THR_BITS-1:0] threshold_i,
  output dcd_pkg::lvl_t                lvl_o,
  output logic [SAMPLE_BITS-1:0]       avg_int_o
);

  localparam int AW = SAMPLE_BITS + FRACTION_BITS;
  localparam int TW = dcd_pkg::THR_BITS + FRACTION_BITS;
  // compare width: room for avg + 2*threshold without overflow
  localparam int CW = ((AW > TW + 1) ? AW : TW + 1) + 1;

  logic          seed_q, seed_d;
  logic [AW-1:0] avg_q, avg_d, avg_upd;
  logic [CW-1:0] smp_fx, avg_ext, thr_fx, sum;
  logic          keep;

  assign smp_fx  = CW'(sample_i) << FRACTION_BITS;
  assign avg_ext = CW'(avg_q);
  assign thr_fx  = CW'(threshold_i) << FRACTION_BITS;

  // outliers more than twice the threshold above do not pull the average
  assign keep    = smp_fx <= avg_ext + (thr_fx << 1);
  assign sum     = smp_fx + avg_ext;
  assign avg_upd = keep ? AW'(sum >> 1) : avg_q;

  always_comb begin
    seed_d     = seed_q;
    avg_d      = avg_q;
    lvl_o.seed = seed_q;
    lvl_o.clap = 1'b0;
    if (advance_i) begin
      seed_d = 1'b0;
      if (seed_q) begin
        avg_d = AW'(smp_fx);
      end else begin
        avg_d      = avg_upd;
        lvl_o.clap = smp_fx > CW'(avg_upd) + thr_fx;
      end
    end
  end

  assign avg_int_o = avg_d[AW-1:FRACTION_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 1'b1;
      avg_q  <= '0;
    end else begin
      seed_q <= seed_d;
      avg_q  <= avg_d;
    end
  end

endmodule

// ===== sv/dcd_clap_window.sv =====
`timescale 1ns / 1ps
// Arming window between two claps; issues the toggle on a double clap.
// Depends on dcd_pkg.
module dcd_clap_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  dcd_pkg::lvl_t                 lvl_i,
  input  logic [dcd_pkg::TIME_BITS-1:0] time_i,
  input  logic [dcd_pkg::WIN_BITS-1:0]  window_i,
  output logic                          toggle_o
);

  logic                          armed_q, armed_d;
  logic [dcd_pkg::TIME_BITS-1:0] last_q, last_d, gap;
  logic                          expired;

  // gap wraps mod 2^32; after a restart the gap is zero, so one compare does
  assign gap     = time_i - last_q;
  assign expired = gap > dcd_pkg::TIME_BITS'(window_i);

  always_comb begin
    armed_d  = armed_q;
    last_d   = last_q;
    toggle_o = 1'b0;
    if (advance_i && !lvl_i.seed) begin
      priority if (lvl_i.clap && !armed_q) begin
        armed_d = 1'b1;
        last_d  = time_i;
      end else if (lvl_i.clap && !expired) begin
        toggle_o = 1'b1;
        armed_d  = 1'b0;
      end else if (lvl_i.clap) begin
        last_d = time_i;
      end else if (armed_q && expired) begin
        armed_d = 1'b0;
      end else begin
        armed_d = armed_q;  // quiet item, window state holds
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      last_q  <= '0;
    end else begin
      armed_q <= armed_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== sv/double_clap_detector.sv =====
`timescale 1ns / 1ps
// Double clap detector, top level. Depends on dcd_pkg, dcd_in_if, dcd_out_if,
// dcd_cfg_regs, dcd_level_tracker and dcd_clap_window.
// Flow: an accepted item is held in the input register and moves on to the
//   result register once the result slot is empty or drains.
// Throughput: one item per cycle while the result side takes items; the
//   average and window state update between the input and result registers.
// Reset: asynchronous, active low; registers return to threshold 100 and
//   window 500 ms, the next item seeds the average, the window is disarmed.
module double_clap_detector #(
  parameter int SAMPLE_BITS   = dcd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = dcd_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [dcd_pkg::DATA_BITS-1:0] pwdata,
  output logic [dcd_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  // sample items in, result items out
  dcd_in_if.sink                        in_i,
  dcd_out_if.source                     out_o
);

  dcd_pkg::cfg_t cfg;
  dcd_pkg::lvl_t lvl;

  // input register stage
  logic                          in_vld_q, in_vld_d;
  logic [SAMPLE_BITS-1:0]        in_sample_q;
  logic [dcd_pkg::TIME_BITS-1:0] in_time_q;
  logic                          in_take;

  // result register stage
  logic                   out_vld_q, out_vld_d;
  logic                   out_toggle_q, out_clap_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;

  logic                   advance;
  logic                   toggle;
  logic [SAMPLE_BITS-1:0] avg_int;

  // An item moves from the input register into the result register when the
  // result slot is empty or drains this cycle. State updates only then.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= in_i.sample;
      in_time_q   <= in_i.time_ms;
    end
    if (advance) begin
      out_toggle_q <= toggle;
      out_clap_q   <= lvl.clap;
      out_avg_q    <= avg_int;
    end
  end

  dcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcd_level_tracker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .sample_i    (in_sample_q),
    .threshold_i (cfg.threshold),
    .lvl_o       (lvl),
    .avg_int_o   (avg_int)
  );

  dcd_clap_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .lvl_i     (lvl),
    .time_i    (in_time_q),
    .window_i  (cfg.window_ms),
    .toggle_o  (toggle)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.toggle        = out_toggle_q;
  assign out_o.clap_seen     = out_clap_q;
  assign out_o.level_average = out_avg_q;

  // a double clap is always a clap
  a_toggle_is_clap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_toggle_q || out_clap_q))
    else $error("toggle without clap_seen");

  // full input stage behind a stalled result must back-pressure
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while both stages are blocked");

  // an item moved on is shown as a result in the next cycle
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register empty after advance");

endmodule
